FILE: hdl/pre_pkg.sv
// Package for the permutation reversal engine: sizes, config indices, opcodes, FSM states, port structs.
// No dependencies.
package pre_pkg;
    localparam int MaxLen = 255;
    localparam int AddrW = 8;
    localparam int ElemW = 9;

    localparam logic CFG_SIGNED = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        MODE_LOAD  = 3'd0,
        MODE_REV   = 3'd1,
        MODE_RDEL  = 3'd2,
        MODE_RDPOS = 3'd3,
        MODE_COUNT = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_REV_RD,
        ST_REV_WAIT,
        ST_REV_WB,
        ST_REV_WE,
        ST_RD_WAIT,
        ST_CNT_RD,
        ST_CNT_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                    we;
        logic [AddrW-1:0]        waddr;
        logic signed [ElemW-1:0] wdata;
        logic [AddrW-1:0]        raddr;
    } elem_port_t;

    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [AddrW-1:0] wdata;
        logic [AddrW-1:0] raddr;
    } inv_port_t;
endpackage

FILE: hdl/permutation_reversal_engine_unit.sv
// Top level of the permutation reversal engine: sequencer around two memories.
// Depends on pre_pkg, pre_elem_mem, pre_inv_mem.
//
//  channel | ports                          | direction
//  s_      | mode first_pos last_pos value  | in,  valid/ready
//  m_      | element .. error               | out, valid/ready
//  cfg     | cfg_we cfg_index cfg_data      | in,  write only
//
// Load and lookups pass from input accept through ST_LOAD to ST_OUT, a lookup
// that reads a store through ST_RD_WAIT as well. Reverse: two reads and two
// write-backs per swapped pair. Count: one element per cycle from the element
// store read port. Reset idles the FSM, clears signed mode and sets the length
// to 255; other registers and the stores are undefined until written.
// One transaction in flight; the result register holds while m_ready is low.
module permutation_reversal_engine_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_mode,
    input  logic [8:0]        s_first_pos,
    input  logic [8:0]        s_last_pos,
    input  logic signed [8:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [9:0] m_element,
    output logic [8:0]        m_where_found,
    output logic [8:0]        m_breakpoints,
    output logic [8:0]        m_unsigned_breakpoints,
    output logic              m_identity,
    output logic              m_error
);
    localparam int AW = pre_pkg::AddrW;

    pre_pkg::state_t state_reg, state_next;
    logic       sgn_reg;
    logic [7:0] len_reg;

    logic [2:0]        mode_reg, mode_next;
    logic [8:0]        p1_reg, p1_next, p2_reg, p2_next;
    logic signed [8:0] val_reg, val_next;
    logic signed [9:0] last_reg, last_next;
    logic [8:0]        ulast_reg, ulast_next;
    logic [8:0]        bp_reg, bp_next, ubp_reg, ubp_next;
    logic              id_reg, id_next;
    logic signed [8:0] x_reg, x_next;

    logic signed [9:0] o_elem_reg, o_elem_next;
    logic [8:0]        o_where_reg, o_where_next;
    logic              o_err_reg, o_err_next;

    pre_pkg::elem_port_t      ep;
    pre_pkg::inv_port_t       ip;
    logic signed [8:0]        erd;
    logic [AW-1:0]            ird;

    pre_elem_mem u_elem (.aclk(aclk), .port(ep), .rdata(erd));
    pre_inv_mem  u_inv  (.aclk(aclk), .port(ip), .rdata(ird));

    logic [8:0]        n9, np1;
    logic [8:0]        aval;
    logic signed [8:0] negx, negy, ywr, xwr;
    logic [8:0]        ay, ax;
    logic signed [9:0] cur, dif;
    logic [8:0]        ucur;
    logic signed [9:0] udif;

    always_comb begin
        n9   = {1'b0, len_reg};
        np1  = n9 + 9'd1;
        aval = val_reg[8] ? 9'(-val_reg) : 9'(val_reg);
        negx = -x_reg;
        negy = -erd;
        xwr  = sgn_reg ? negx : x_reg;
        ywr  = sgn_reg ? negy : erd;
        ax   = xwr[8] ? 9'(-xwr) : 9'(xwr);
        ay   = ywr[8] ? 9'(-ywr) : 9'(ywr);
        cur  = (p1_reg == 9'd0) ? 10'sd0 : 10'(erd);
        ucur = cur[9] ? 9'(-cur) : 9'(cur);
        dif  = last_reg - cur;
        udif = 10'($signed({1'b0, ulast_reg})) - 10'($signed({1'b0, ucur}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pre_pkg::ST_IDLE;
            sgn_reg   <= 1'b0;
            len_reg   <= 8'd255;
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == pre_pkg::CFG_SIGNED) sgn_reg <= cfg_data[0];
            if (cfg_we && cfg_index == pre_pkg::CFG_LENGTH) len_reg <= cfg_data;
        end
        mode_reg <= mode_next; p1_reg <= p1_next; p2_reg <= p2_next;
        val_reg <= val_next; last_reg <= last_next; ulast_reg <= ulast_next;
        bp_reg <= bp_next; ubp_reg <= ubp_next; id_reg <= id_next;
        x_reg <= x_next;
        o_elem_reg <= o_elem_next; o_where_reg <= o_where_next;
        o_err_reg <= o_err_next;
    end

    always_comb begin
        state_next = state_reg;
        mode_next = mode_reg; p1_next = p1_reg; p2_next = p2_reg;
        val_next = val_reg; last_next = last_reg; ulast_next = ulast_reg;
        bp_next = bp_reg; ubp_next = ubp_reg; id_next = id_reg;
        x_next = x_reg;
        o_elem_next = o_elem_reg; o_where_next = o_where_reg;
        o_err_next = o_err_reg;
        ep = '0; ip = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;

        unique case (state_reg)
            pre_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mode_next = s_mode; p1_next = s_first_pos;
                    p2_next = s_last_pos; val_next = s_value;
                    o_elem_next = '0; o_where_next = '0; o_err_next = 1'b0;
                    bp_next = '0; ubp_next = '0; id_next = 1'b0;
                    state_next = pre_pkg::ST_LOAD;
                end
            end
            pre_pkg::ST_LOAD: begin
                state_next = pre_pkg::ST_OUT;
                priority case (mode_reg)
                    pre_pkg::MODE_LOAD: begin
                        if (p1_reg == 9'd0 || p1_reg > n9 || val_reg == 9'sd0 ||
                            aval > n9 || (val_reg[8] && !sgn_reg)) begin
                            o_err_next = 1'b1;
                        end else begin
                            ep.we = 1'b1; ep.waddr = AW'(p1_reg - 9'd1);
                            ep.wdata = val_reg;
                            ip.we = 1'b1; ip.waddr = AW'(aval - 9'd1);
                            ip.wdata = AW'(p1_reg);
                        end
                    end
                    pre_pkg::MODE_REV: begin
                        if (p1_reg == 9'd0 || p1_reg > n9 ||
                            p2_reg == 9'd0 || p2_reg > n9) begin
                            o_err_next = 1'b1;
                        end else begin
                            state_next = pre_pkg::ST_REV_RD;
                        end
                    end
                    pre_pkg::MODE_RDEL: begin
                        if (p1_reg > np1) o_err_next = 1'b1;
                        else if (p1_reg == np1) o_elem_next = 10'(np1);
                        else if (p1_reg != 9'd0) begin
                            ep.raddr = AW'(p1_reg - 9'd1);
                            state_next = pre_pkg::ST_RD_WAIT;
                        end
                    end
                    pre_pkg::MODE_RDPOS: begin
                        if (aval > np1) o_err_next = 1'b1;
                        else if (aval == np1) o_where_next = np1;
                        else if (aval != 9'd0) begin
                            ip.raddr = AW'(aval - 9'd1);
                            state_next = pre_pkg::ST_RD_WAIT;
                        end
                    end
                    pre_pkg::MODE_COUNT: begin
                        last_next = 10'(np1); ulast_next = np1;
                        id_next = 1'b1; p1_next = n9;
                        state_next = pre_pkg::ST_CNT_RD;
                    end
                    default: o_err_next = 1'b1;
                endcase
            end
            pre_pkg::ST_REV_RD: begin
                if (p1_reg > p2_reg) begin
                    state_next = pre_pkg::ST_OUT;
                end else begin
                    ep.raddr = AW'(p1_reg - 9'd1);
                    state_next = pre_pkg::ST_REV_WAIT;
                end
            end
            pre_pkg::ST_REV_WAIT: begin
                x_next = erd;
                ep.raddr = AW'(p2_reg - 9'd1);
                state_next = pre_pkg::ST_REV_WB;
            end
            pre_pkg::ST_REV_WB: begin
                ep.we = 1'b1; ep.waddr = AW'(p1_reg - 9'd1); ep.wdata = ywr;
                ip.we = (ay != 9'd0); ip.waddr = AW'(ay - 9'd1);
                ip.wdata = AW'(p1_reg);
                state_next = pre_pkg::ST_REV_WE;
            end
            pre_pkg::ST_REV_WE: begin
                ep.we = 1'b1; ep.waddr = AW'(p2_reg - 9'd1); ep.wdata = xwr;
                ip.we = (ax != 9'd0); ip.waddr = AW'(ax - 9'd1);
                ip.wdata = AW'(p2_reg);
                p1_next = p1_reg + 9'd1;
                p2_next = p2_reg - 9'd1;
                state_next = (p2_reg == 9'd1) ? pre_pkg::ST_OUT : pre_pkg::ST_REV_RD;
            end
            pre_pkg::ST_RD_WAIT: begin
                if (mode_reg == pre_pkg::MODE_RDEL) o_elem_next = 10'(erd);
                else o_where_next = {1'b0, ird};
                state_next = pre_pkg::ST_OUT;
            end
            pre_pkg::ST_CNT_RD: begin
                ep.raddr = AW'(p1_reg - 9'd1);
                state_next = pre_pkg::ST_CNT_ACC;
            end
            pre_pkg::ST_CNT_ACC: begin
                if (sgn_reg ? (dif != 10'sd1) : (dif != 10'sd1 && dif != -10'sd1))
                    bp_next = bp_reg + 9'd1;
                if (udif != 10'sd1 && udif != -10'sd1) ubp_next = ubp_reg + 9'd1;
                if (p1_reg != 9'd0 && cur != 10'($signed({1'b0, p1_reg})))
                    id_next = 1'b0;
                last_next = cur; ulast_next = ucur;
                if (p1_reg == 9'd0) begin
                    state_next = pre_pkg::ST_OUT;
                end else begin
                    p1_next = p1_reg - 9'd1;
                    ep.raddr = AW'(p1_reg - 9'd2);
                end
            end
            pre_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = pre_pkg::ST_IDLE;
            end
            default: state_next = pre_pkg::ST_IDLE;
        endcase
    end

    assign m_element              = o_elem_reg;
    assign m_where_found          = o_where_reg;
    assign m_breakpoints          = bp_reg;
    assign m_unsigned_breakpoints = ubp_reg;
    assign m_identity             = id_reg;
    assign m_error                = o_err_reg;
endmodule

FILE: hdl/pre_elem_mem.sv
// Element store: one write port, one registered read port.
// Depends on pre_pkg.
module pre_elem_mem (
    input  logic                                   aclk,
    input  pre_pkg::elem_port_t                    port,
    output logic signed [pre_pkg::ElemW-1:0]       rdata
);
    logic signed [pre_pkg::ElemW-1:0] mem [pre_pkg::MaxLen];

    always_ff @(posedge aclk) begin
        if (port.we) begin
            mem[port.waddr] <= port.wdata;
        end
        rdata <= mem[port.raddr];
    end
endmodule

FILE: hdl/pre_inv_mem.sv
// Inverse store: position of each absolute value, registered read.
// Depends on pre_pkg.
module pre_inv_mem (
    input  logic                          aclk,
    input  pre_pkg::inv_port_t            port,
    output logic [pre_pkg::AddrW-1:0]     rdata
);
    logic [pre_pkg::AddrW-1:0] mem [pre_pkg::MaxLen];

    always_ff @(posedge aclk) begin
        if (port.we) begin
            mem[port.waddr] <= port.wdata;
        end
        rdata <= mem[port.raddr];
    end
endmodule

FILE: dv/permutation_reversal_checker.sv
// Checker for the permutation reversal engine: watches config writes and both
// channels, keeps its own permutation, inverse and registers, compares results.
// Depends on pre_pkg.
module permutation_reversal_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [2:0]        s_mode,
    input  logic [8:0]        s_first_pos,
    input  logic [8:0]        s_last_pos,
    input  logic signed [8:0] s_value,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic signed [9:0] m_element,
    input  logic [8:0]        m_where_found,
    input  logic [8:0]        m_breakpoints,
    input  logic [8:0]        m_unsigned_breakpoints,
    input  logic              m_identity,
    input  logic              m_error,
    output int                pending,
    output int                failures
);
    typedef struct packed {
        logic signed [9:0] element;
        logic [8:0]        where_found;
        logic [8:0]        breakpoints;
        logic [8:0]        unsigned_breakpoints;
        logic              identity;
        logic              error;
    } outcome_t;

    outcome_t   expected_results[$];
    int         perm_at[256];
    int         pos_of[256];
    logic       signed_on;
    logic [7:0] perm_len;

    function automatic int magnitude(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int perm_value(int pos, int n);
        if (pos <= 0) return 0;
        if (pos == n + 1) return n + 1;
        if (pos > pre_pkg::MaxLen) return 0;
        return perm_at[pos];
    endfunction

    function automatic void track_position(int e, int pos);
        int a;
        a = magnitude(e);
        if (a >= 1 && a <= pre_pkg::MaxLen) pos_of[a] = pos;
    endfunction

    function automatic outcome_t apply_transaction(logic [2:0] md, logic [8:0] p1v,
                                                   logic [8:0] p2v,
                                                   logic signed [8:0] v);
        outcome_t r;
        int p1, p2, val, n, a, b, e, x, y, last, ulast, cur, ucur, bp, ubp, ident;
        r = '0;
        p1 = p1v;
        p2 = p2v;
        val = v;
        n = (perm_len > pre_pkg::MaxLen) ? pre_pkg::MaxLen : perm_len;
        bp = 0;
        ubp = 0;
        ident = 0;
        case (md)
            pre_pkg::MODE_LOAD: begin
                a = magnitude(val);
                if (p1 < 1 || p1 > n || val == 0 || a > n || (val < 0 && !signed_on)) begin
                    r.error = 1'b1;
                end else begin
                    perm_at[p1] = val;
                    track_position(val, p1);
                end
            end
            pre_pkg::MODE_REV: begin
                if (p1 < 1 || p1 > n || p2 < 1 || p2 > n) begin
                    r.error = 1'b1;
                end else begin
                    b = p1;
                    e = p2;
                    while (b <= e) begin
                        x = perm_at[b];
                        y = perm_at[e];
                        if (signed_on) begin
                            x = -x;
                            y = -y;
                        end
                        perm_at[b] = y;
                        perm_at[e] = x;
                        track_position(y, b);
                        track_position(x, e);
                        b++;
                        e--;
                    end
                end
            end
            pre_pkg::MODE_RDEL: begin
                if (p1 > n + 1) r.error = 1'b1;
                else r.element = 10'(perm_value(p1, n));
            end
            pre_pkg::MODE_RDPOS: begin
                a = magnitude(val);
                if (a > n + 1) r.error = 1'b1;
                else if (a == 0) r.where_found = '0;
                else if (a == n + 1) r.where_found = 9'(n + 1);
                else r.where_found = 9'(pos_of[a]);
            end
            pre_pkg::MODE_COUNT: begin
                last = n + 1;
                ulast = n + 1;
                ident = 1;
                for (int i = n; i >= 0; i--) begin
                    cur = perm_value(i, n);
                    ucur = magnitude(cur);
                    if (signed_on) begin
                        if (last - cur != 1) bp++;
                    end else if (magnitude(last - cur) != 1) begin
                        bp++;
                    end
                    if (magnitude(ulast - ucur) != 1) ubp++;
                    if (i >= 1 && cur != i) ident = 0;
                    last = cur;
                    ulast = ucur;
                end
                r.breakpoints = 9'(bp);
                r.unsigned_breakpoints = 9'(ubp);
                r.identity = 1'(ident);
            end
            default: r.error = 1'b1;
        endcase
        return r;
    endfunction

    initial failures = 0;

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            signed_on <= 1'b0;
            perm_len <= 8'd255;
            expected_results.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_element !== want.element) begin
                        $error("element: expected %0d, got %0d", want.element, m_element);
                        failures++;
                    end
                    if (m_where_found !== want.where_found) begin
                        $error("where_found: expected %0d, got %0d", want.where_found,
                               m_where_found);
                        failures++;
                    end
                    if (m_breakpoints !== want.breakpoints) begin
                        $error("breakpoints: expected %0d, got %0d", want.breakpoints,
                               m_breakpoints);
                        failures++;
                    end
                    if (m_unsigned_breakpoints !== want.unsigned_breakpoints) begin
                        $error("unsigned_breakpoints: expected %0d, got %0d",
                               want.unsigned_breakpoints, m_unsigned_breakpoints);
                        failures++;
                    end
                    if (m_identity !== want.identity) begin
                        $error("identity: expected %0d, got %0d", want.identity, m_identity);
                        failures++;
                    end
                    if (m_error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, m_error);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_transaction(s_mode, s_first_pos,
                                                             s_last_pos, s_value));
            pending <= expected_results.size();
            if (cfg_we) begin
                if (cfg_index == pre_pkg::CFG_SIGNED) signed_on <= cfg_data[0];
                else perm_len <= cfg_data;
            end
        end
    end
endmodule

FILE: dv/tb_permutation_reversal_engine_unit.sv
// Testbench top for permutation_reversal_engine_unit: drives config writes,
// loads, reversals, lookups, counts and undefined modes with random idling; verdict from the checker.
// Depends on pre_pkg, permutation_reversal_engine_unit, permutation_reversal_checker.
module tb_permutation_reversal_engine_unit;
    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic              cfg_index;
    logic [7:0]        cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [2:0]        s_mode;
    logic [8:0]        s_first_pos;
    logic [8:0]        s_last_pos;
    logic signed [8:0] s_value;
    logic              m_valid;
    logic              m_ready;
    logic signed [9:0] m_element;
    logic [8:0]        m_where_found;
    logic [8:0]        m_breakpoints;
    logic [8:0]        m_unsigned_breakpoints;
    logic              m_identity;
    logic              m_error;
    int                pending;
    int                failures;

    int   sent;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cycles;
    logic pressure_done;
    int   cur_len;
    logic cur_signed;

    permutation_reversal_engine_unit DUT (.*);

    permutation_reversal_checker checker_i (.*);

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always_comb begin
        if (sent < 350) begin
            send_idle_pct = 32;
            recv_idle_pct = 68;
        end else if (sent < 700) begin
            send_idle_pct = 68;
            recv_idle_pct = 32;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cycles <= 0;
            pressure_done <= 1'b0;
        end else if (!pressure_done && sent >= 150) begin
            pressure_done <= 1'b1;
            hold_cycles <= 400;
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send(logic [2:0] md, int p1, int p2, int v);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_first_pos <= 9'(p1);
        s_last_pos <= 9'(p2);
        s_value <= 9'(v);
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic send_raw(logic [2:0] md);
        send(md, $urandom_range(0, 511), $urandom_range(0, 511),
             $urandom_range(0, 511));
    endtask

    task automatic configure(logic sm, int n);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= pre_pkg::CFG_SIGNED;
        cfg_data <= 8'(sm);
        @(posedge aclk);
        cfg_index <= pre_pkg::CFG_LENGTH;
        cfg_data <= 8'(n);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_len = n;
        cur_signed = sm;
    endtask

    task automatic load_permutation();
        int perm[256];
        int j, t, v;
        for (int i = 1; i <= cur_len; i++) perm[i] = i;
        for (int i = cur_len; i > 1; i--) begin
            j = $urandom_range(1, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 1; i <= cur_len; i++) begin
            v = perm[i];
            if (cur_signed && $urandom_range(0, 1)) v = -v;
            send(pre_pkg::MODE_LOAD, i, $urandom_range(0, 511), v);
        end
    endtask

    task automatic directed_items();
        int n;
        n = cur_len;
        send(pre_pkg::MODE_LOAD, 1, 0, 0);
        send(pre_pkg::MODE_LOAD, 2, 511, n + 1);
        send(pre_pkg::MODE_LOAD, 3, 0, -3);
        send(pre_pkg::MODE_LOAD, 0, 0, 1);
        send(pre_pkg::MODE_LOAD, n + 1, 0, 1);
        send(pre_pkg::MODE_LOAD, 256, 256, -256);
        send(pre_pkg::MODE_REV, 0, 3, 0);
        send(pre_pkg::MODE_REV, 2, n + 1, 0);
        send(pre_pkg::MODE_REV, 5, 2, 0);
        send(pre_pkg::MODE_REV, 1, n, 0);
        send(pre_pkg::MODE_REV, 3, 3, 0);
        send(pre_pkg::MODE_RDEL, 0, 0, 0);
        send(pre_pkg::MODE_RDEL, n + 1, 0, 0);
        send(pre_pkg::MODE_RDEL, n + 2, 0, 0);
        send(pre_pkg::MODE_RDEL, 511, 511, 255);
        send(pre_pkg::MODE_RDPOS, 0, 0, 0);
        send(pre_pkg::MODE_RDPOS, 0, 0, n + 1);
        send(pre_pkg::MODE_RDPOS, 0, 0, -(n + 1));
        send(pre_pkg::MODE_RDPOS, 0, 0, n + 2);
        send(pre_pkg::MODE_RDPOS, 0, 0, -256);
        send(pre_pkg::MODE_COUNT, 0, 0, 0);
        send_raw(3'd5);
        send_raw(3'd6);
        send_raw(3'd7);
    endtask

    task automatic random_item();
        int r, n, v;
        logic junk;
        n = cur_len;
        r = $urandom_range(0, 99);
        junk = ($urandom_range(0, 9) == 0);
        v = $urandom_range(1, n);
        if ($urandom_range(0, 1)) v = -v;
        if (r < 15) begin
            if (junk) send_raw(pre_pkg::MODE_LOAD);
            else send(pre_pkg::MODE_LOAD, $urandom_range(1, n), $urandom_range(0, 511), v);
        end else if (r < 55) begin
            if (junk) send_raw(pre_pkg::MODE_REV);
            else send(pre_pkg::MODE_REV, $urandom_range(1, n), $urandom_range(1, n),
                      $urandom_range(0, 511));
        end else if (r < 70) begin
            if (junk) send_raw(pre_pkg::MODE_RDEL);
            else send(pre_pkg::MODE_RDEL, $urandom_range(0, n + 1),
                      $urandom_range(0, 511), $urandom_range(0, 511));
        end else if (r < 85) begin
            if (junk) send_raw(pre_pkg::MODE_RDPOS);
            else send(pre_pkg::MODE_RDPOS, $urandom_range(0, 511), $urandom_range(0, 511),
                      $urandom_range(0, 1) ? $urandom_range(0, n + 1)
                                           : -$urandom_range(0, n + 1));
        end else if (r < 97) begin
            send_raw(pre_pkg::MODE_COUNT);
        end else begin
            send_raw(3'($urandom_range(5, 7)));
        end
    endtask

    task automatic run_phase(logic sm, int n, int count, logic with_directed);
        configure(sm, n);
        load_permutation();
        if (with_directed) directed_items();
        repeat (count) random_item();
    endtask

    initial begin
        #(12 * 4000000);
        $display("tb_permutation_reversal_engine_unit failed");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_mode = '0;
        s_first_pos = '0;
        s_last_pos = '0;
        s_value = '0;
        sent = 0;
        cur_len = 255;
        cur_signed = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_phase(1'b0, 8, 40, 1'b1);
        run_phase(1'b1, 8, 40, 1'b0);
        run_phase(1'b1, 1, 20, 1'b0);
        run_phase(1'b0, 2, 20, 1'b0);
        run_phase(1'b1, 37, 50, 1'b0);
        run_phase(1'b1, 255, 20, 1'b0);
        run_phase(1'b0, 255, 20, 1'b0);
        run_phase(1'b0, 100, 20, 1'b0);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (300) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("tb_permutation_reversal_engine_unit passed");
        end else begin
            $display("tb_permutation_reversal_engine_unit failed");
        end
        $finish;
    end
endmodule
